>>> src/tqpr_pkg.sv
// Package: shared constants, opcodes and payload types for the two-queue replacement core
package tqpr_pkg;
    localparam int FIFO_DEPTH = 16;
    localparam int LRU_DEPTH = 16;
    localparam int PIN_DEPTH = 16;
    localparam int FW = $clog2(FIFO_DEPTH);
    localparam int LW = $clog2(LRU_DEPTH);
    localparam int PW = $clog2(PIN_DEPTH);
    localparam int FCW = $clog2(FIFO_DEPTH + 1);
    localparam int LCW = $clog2(LRU_DEPTH + 1);
    localparam int PCW = $clog2(PIN_DEPTH + 1);

    localparam logic [2:0] OP_KNOW = 3'd0;
    localparam logic [2:0] OP_FORGET = 3'd1;
    localparam logic [2:0] OP_USED = 3'd2;
    localparam logic [2:0] OP_PIN = 3'd3;
    localparam logic [2:0] OP_RELEASE = 3'd4;
    localparam logic [2:0] OP_SETPIN = 3'd5;
    localparam logic [2:0] OP_VICTIM = 3'd6;
    localparam logic [2:0] OP_NOP = 3'd7;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [63:0] page_id;
        logic        pin_value;
    } t_in;

    typedef struct packed {
        logic [63:0] victim_id;
        logic        victim_found;
        logic        pin_busy;
        logic        queue_full;
        logic        pin_table_full;
        logic [5:0]  occupancy;
    } t_out;

    typedef struct packed {
        logic        start;
        logic [63:0] key;
    } t_pin_req;

    typedef struct packed {
        logic          done;
        logic          hit;
        logic [PW-1:0] hit_idx;
        logic          has_free;
        logic [PW-1:0] free_idx;
    } t_pin_rsp;
endpackage

>>> src/tqpr_pin_table.sv
// Pin table: serial search for a key and the lowest free slot, plus set and clear of entries
module tqpr_pin_table
    import tqpr_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_pin_req      i_req,
    input  logic          i_set,
    input  logic          i_clr,
    input  logic [PW-1:0] i_idx,
    input  logic [63:0]   i_id,
    output t_pin_rsp      o_rsp
);
    logic [63:0]          r_ids [PIN_DEPTH];
    logic [PIN_DEPTH-1:0] r_valid;
    logic                 r_busy;
    logic [PCW-1:0]       r_i;
    logic [63:0]          r_key;
    t_pin_rsp             r_rsp;
    logic [PW-1:0]        w_i;

    assign w_i = r_i[PW-1:0];
    assign o_rsp = r_rsp;

    always_ff @(posedge i_clk) begin
        if (i_set) r_ids[i_idx] <= i_id;
        if (!i_rst_n) begin
            r_valid <= '0;
            r_busy <= 1'b0;
            r_rsp <= '0;
            r_i <= '0;
        end else begin
            if (i_set) r_valid[i_idx] <= 1'b1;
            if (i_clr) r_valid[i_idx] <= 1'b0;
            r_rsp.done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_i <= '0;
                r_key <= i_req.key;
                r_rsp.hit <= 1'b0;
                r_rsp.has_free <= 1'b0;
            end else if (r_busy) begin
                if (r_valid[w_i] && r_ids[w_i] == r_key && !r_rsp.hit) begin
                    r_rsp.hit <= 1'b1;
                    r_rsp.hit_idx <= w_i;
                end
                if (!r_valid[w_i] && !r_rsp.has_free) begin
                    r_rsp.has_free <= 1'b1;
                    r_rsp.free_idx <= w_i;
                end
                if (r_i == PCW'(PIN_DEPTH - 1)) begin
                    r_busy <= 1'b0;
                    r_rsp.done <= 1'b1;
                end
                r_i <= r_i + 1'b1;
            end
        end
    end
endmodule

>>> src/two_queue_page_replacement_core.sv
// Top level: two-queue page replacement core with sequencer over FIFO, LRU and pin table
// Usage:
//   Input channel i_valid/o_ready carries one operation (t_in) per transfer.
//   Output channel o_valid/i_ready returns exactly one result (t_out) per op.
//   One op is taken at a time; o_ready is low from accept until the result
//   has been transferred. The time taken depends on the op and queue fill:
//   know/forget/used walk each queue entry by entry (one entry per cycle,
//   shifting entries down on removal), pin ops scan all PIN_DEPTH slots in
//   the pin table unit, and find victim runs one pin scan per queue entry
//   examined. The shared pin table compare unit and single-entry queue walk
//   set the time taken. Reset (synchronous, active low) empties both queues
//   and the pin table. If the receiver stalls, the result holds in the
//   output register and no new op is accepted until it is taken.
module two_queue_page_replacement_core
    import tqpr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);
    typedef enum logic [3:0] {
        S_IDLE, S_FSCAN, S_LSCAN, S_FSHIFT, S_LSHIFT, S_DECIDE,
        S_PSTART, S_PWAIT, S_VSTART, S_VWAIT, S_OUT
    } t_state;

    t_state         r_state;
    t_in            r_op;
    logic [63:0]    r_fifo [FIFO_DEPTH];
    logic [63:0]    r_lru [LRU_DEPTH];
    logic [FCW-1:0] r_fcnt;
    logic [LCW-1:0] r_lcnt;
    logic [FCW-1:0] r_fi;
    logic [LCW-1:0] r_li;
    logic           r_fhit;
    logic           r_lhit;
    logic [1:0]     r_step;
    logic           r_inlru;
    t_out           r_out;
    logic [63:0]    r_cand;
    t_pin_req       w_preq;
    t_pin_rsp       w_prsp;
    logic           w_pset;
    logic           w_pclr;
    logic [PW-1:0]  w_pidx;
    logic [FW-1:0]  w_fi;
    logic [LW-1:0]  w_li;

    assign w_fi = r_fi[FW-1:0];
    assign w_li = r_li[LW-1:0];
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);

    always_comb begin
        o_data = r_out;
        o_data.occupancy = 6'(r_fcnt) + 6'(r_lcnt);
    end

    always_comb begin
        w_preq.start = (r_state == S_PSTART) || (r_state == S_VSTART);
        w_preq.key = (r_state == S_VSTART) ? r_cand : r_op.page_id;
        w_pidx = w_prsp.hit ? w_prsp.hit_idx : w_prsp.free_idx;
        w_pset = 1'b0;
        w_pclr = 1'b0;
        if (r_state == S_PWAIT && w_prsp.done) begin
            if (r_op.opcode == OP_RELEASE ||
                (r_op.opcode == OP_SETPIN && !r_op.pin_value)) begin
                w_pclr = w_prsp.hit;
            end else begin
                w_pset = !w_prsp.hit && w_prsp.has_free;
            end
        end
    end

    tqpr_pin_table u_pin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_preq),
        .i_set   (w_pset),
        .i_clr   (w_pclr),
        .i_idx   (w_pidx),
        .i_id    (r_op.page_id),
        .o_rsp   (w_prsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fcnt <= '0;
            r_lcnt <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_op <= i_data;
                        r_out <= '0;
                        r_fi <= '0;
                        r_li <= '0;
                        r_fhit <= 1'b0;
                        r_lhit <= 1'b0;
                        r_step <= 2'd0;
                        r_inlru <= 1'b0;
                        case (i_data.opcode)
                            OP_KNOW, OP_FORGET, OP_USED: r_state <= S_LSCAN;
                            OP_PIN, OP_RELEASE, OP_SETPIN: r_state <= S_PSTART;
                            OP_VICTIM: r_state <= S_VSTART;
                            default: r_state <= S_OUT;
                        endcase
                    end
                end
                S_LSCAN: begin
                    if (r_li >= r_lcnt) begin
                        r_fi <= '0;
                        r_state <= S_FSCAN;
                    end else if (r_lru[w_li] == r_op.page_id) begin
                        r_lhit <= 1'b1;
                        if (r_op.opcode == OP_KNOW) begin
                            r_state <= S_DECIDE;
                        end else begin
                            r_state <= S_LSHIFT;
                        end
                    end else begin
                        r_li <= r_li + 1'b1;
                    end
                end
                S_LSHIFT: begin
                    if (r_li + 1'b1 < r_lcnt) begin
                        r_lru[w_li] <= r_lru[LW'(r_li + 1'b1)];
                        r_li <= r_li + 1'b1;
                    end else begin
                        r_lcnt <= r_lcnt - 1'b1;
                        if (r_op.opcode == OP_USED) begin
                            r_lru[w_li] <= r_op.page_id;
                            r_lcnt <= r_lcnt;
                            r_inlru <= 1'b1;
                        end
                        r_fi <= '0;
                        r_state <= S_FSCAN;
                    end
                end
                S_FSCAN: begin
                    if (r_fi >= r_fcnt) begin
                        r_state <= S_DECIDE;
                    end else if (r_fifo[w_fi] == r_op.page_id) begin
                        r_fhit <= 1'b1;
                        if (r_op.opcode == OP_KNOW) begin
                            r_state <= S_DECIDE;
                        end else begin
                            r_state <= S_FSHIFT;
                        end
                    end else begin
                        r_fi <= r_fi + 1'b1;
                    end
                end
                S_FSHIFT: begin
                    if (r_fi + 1'b1 < r_fcnt) begin
                        r_fifo[w_fi] <= r_fifo[FW'(r_fi + 1'b1)];
                        r_fi <= r_fi + 1'b1;
                    end else begin
                        r_fcnt <= r_fcnt - 1'b1;
                        if (r_op.opcode == OP_USED) begin
                            if (r_lcnt < LCW'(LRU_DEPTH)) begin
                                r_lru[LW'(r_lcnt)] <= r_op.page_id;
                                r_lcnt <= r_lcnt + 1'b1;
                                r_inlru <= 1'b1;
                            end else begin
                                r_out.queue_full <= 1'b1;
                            end
                        end
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if ((r_op.opcode == OP_KNOW && !r_fhit && !r_lhit) ||
                        (r_op.opcode == OP_USED && !r_inlru)) begin
                        if (r_fcnt < FCW'(FIFO_DEPTH)) begin
                            r_fifo[FW'(r_fcnt)] <= r_op.page_id;
                            r_fcnt <= r_fcnt + 1'b1;
                        end else begin
                            r_out.queue_full <= 1'b1;
                        end
                    end
                    r_state <= S_OUT;
                end
                S_PSTART: r_state <= S_PWAIT;
                S_PWAIT: begin
                    if (w_prsp.done) begin
                        if (r_op.opcode == OP_PIN && w_prsp.hit) begin
                            r_out.pin_busy <= 1'b1;
                        end else if ((r_op.opcode == OP_PIN || (r_op.opcode == OP_SETPIN
                                     && r_op.pin_value)) && !w_prsp.hit
                                     && !w_prsp.has_free) begin
                            r_out.pin_table_full <= 1'b1;
                        end
                        r_state <= S_OUT;
                    end
                end
                S_VSTART: begin
                    if (r_step == 2'd0 && r_fi < r_fcnt) begin
                        r_cand <= r_fifo[w_fi];
                        r_step <= 2'd1;
                    end else if (r_step == 2'd0) begin
                        r_step <= 2'd2;
                    end else if (r_step == 2'd2 && r_li < r_lcnt) begin
                        r_cand <= r_lru[w_li];
                        r_step <= 2'd3;
                    end else if (r_step == 2'd2) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_VWAIT;
                    end
                end
                S_VWAIT: begin
                    if (w_prsp.done) begin
                        if (!w_prsp.hit) begin
                            r_out.victim_id <= r_cand;
                            r_out.victim_found <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            if (r_step == 2'd1) begin
                                r_fi <= r_fi + 1'b1;
                                r_step <= 2'd0;
                            end else begin
                                r_li <= r_li + 1'b1;
                                r_step <= 2'd2;
                            end
                            r_state <= S_VSTART;
                        end
                    end
                end
                S_OUT: begin
                    if (i_ready)
                        r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

>>> src/tqpr_checker.sv
// Checker: port-level assertions for the two-queue replacement core, with bind
module tqpr_checker
    import tqpr_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready,
    input t_out o_data
);
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result changed while stalled");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("ready while result pending");
    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready right after transfer");
    a_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.occupancy <= 6'(FIFO_DEPTH + LRU_DEPTH))
        else $error("occupancy out of range");
    a_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.victim_found |-> o_data.victim_id == 64'd0)
        else $error("victim id without found");
endmodule

bind two_queue_page_replacement_core tqpr_checker u_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);
